/* sv/tfaml_pkg.sv */
// Shared types and constants for the throttle-from-acceleration map lookup.
package tfaml_pkg;

  localparam int VAL_W      = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 4;
  localparam int NUM_W      = 33;  // dividend magnitude bits
  localparam int DEN_W      = 16;  // divisor magnitude bits

  localparam logic [CFG_IDX_W-1:0] CFG_VEL_COLS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_ROWS = 4'd1;

  typedef enum logic [1:0] {
    FUNC_WR_VEL  = 2'd0,
    FUNC_WR_THR  = 2'd1,
    FUNC_WR_CELL = 2'd2,
    FUNC_QUERY   = 2'd3
  } func_t;

  typedef struct packed {
    func_t                   func;
    logic [2:0]              row;
    logic [2:0]              col;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] target_accel;
    logic signed [VAL_W-1:0] speed;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] throttle_out;
    logic                    in_throttle_area;
    logic                    at_max_throttle;
  } out_t;

  typedef struct packed {
    logic write_en;
    logic load_q;
    logic phase;       // 0 velocity stage, 1 throttle stage
    logic prev_ld;
    logic hit_interp;
    logic hit_clamp;
    logic ylo_ld;
    logic yhi_ld;
    logic mul;
    logic div_start;
    logic acc_wr;
    logic out_fire;
    logic out_brake;
    logic out_max;
  } cmd_t;

  typedef struct packed {
    logic q_lt_x;
    logic q_le_x;
    logic den_pos;
    logic div_done;
  } stat_t;

endpackage

/* sv/tfaml_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module tfaml_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [tfaml_pkg::NUM_W-1:0]  dividend,
  input  logic [tfaml_pkg::DEN_W-1:0]  divisor,
  output logic [tfaml_pkg::NUM_W-1:0]  quotient,
  output logic                         done
);

  localparam int NW = tfaml_pkg::NUM_W;
  localparam int DW = tfaml_pkg::DEN_W;
  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    quo_r, quo_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [DW:0]      rem_sh;
  logic [DW:0]      rem_sub;

  assign rem_sh  = {rem_r, quo_r[NW-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      den_nxt = divisor;
      cnt_nxt = CNT_W'(NW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = rem_sub[DW-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DW-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

/* sv/tfaml_dpath.sv */
// Datapath: table memories, compares, multiplier, divider and result register.
module tfaml_dpath #(
  parameter int MAXC = 8,
  parameter int MAXR = 8,
  parameter int IW   = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tfaml_pkg::in_t      in_data,
  input  tfaml_pkg::cmd_t     cmd,
  input  logic [IW-1:0]       x_addr,
  input  logic [IW-1:0]       y_idx,
  input  logic [IW-1:0]       y_row,
  output tfaml_pkg::stat_t    st,
  output logic                out_valid,
  output tfaml_pkg::out_t     out_data
);

  localparam int CW = $clog2(MAXC);
  localparam int RW = $clog2(MAXR);
  localparam int AW = $clog2(MAXR * MAXC);

  logic signed [15:0] vbp_mem  [MAXC];
  logic signed [15:0] tbp_mem  [MAXR];
  logic signed [15:0] cell_mem [MAXR*MAXC];
  logic signed [15:0] acc_mem  [MAXR];

  logic signed [15:0] vbp_rd_r, tbp_rd_r, cell_rd_r, acc_rd_r;
  logic signed [15:0] spd_r, tgt_r, prev_r, xlo_r, xhi_r, ylo_r, yhi_r;
  logic signed [33:0] num_r;
  logic signed [16:0] den_r;
  logic               out_valid_r;
  tfaml_pkg::out_t    out_r;

  logic signed [15:0] x_rd, y_rd, q_sel, res;
  logic signed [16:0] dq, dy, dx;
  logic signed [33:0] prod, num_abs, squot;
  logic signed [34:0] sum;
  logic [tfaml_pkg::NUM_W-1:0] quot;
  logic               div_done;
  logic [31:0]        wr_row, wr_col;
  logic [AW-1:0]      cell_rd_addr, cell_wr_addr;

  assign wr_row = 32'(in_data.row);
  assign wr_col = 32'(in_data.col);
  assign cell_wr_addr = AW'(wr_row * MAXC + wr_col);
  assign cell_rd_addr = AW'(32'(y_row[RW-1:0]) * MAXC + 32'(y_idx[CW-1:0]));

  // table writes
  always_ff @(posedge clk) begin
    if (cmd.write_en) begin
      unique case (in_data.func)
        tfaml_pkg::FUNC_WR_VEL:
          if (wr_col < MAXC) vbp_mem[wr_col[CW-1:0]] <= in_data.value;
        tfaml_pkg::FUNC_WR_THR:
          if (wr_row < MAXR) tbp_mem[wr_row[RW-1:0]] <= in_data.value;
        tfaml_pkg::FUNC_WR_CELL:
          if (wr_row < MAXR && wr_col < MAXC) cell_mem[cell_wr_addr] <= in_data.value;
        tfaml_pkg::FUNC_QUERY: ;
        default: ;
      endcase
    end
    if (cmd.acc_wr) acc_mem[y_row[RW-1:0]] <= res;
  end

  // registered reads
  always_ff @(posedge clk) begin
    vbp_rd_r  <= vbp_mem[x_addr[CW-1:0]];
    acc_rd_r  <= acc_mem[x_addr[RW-1:0]];
    tbp_rd_r  <= tbp_mem[y_idx[RW-1:0]];
    cell_rd_r <= cell_mem[cell_rd_addr];
  end

  assign x_rd  = cmd.phase ? acc_rd_r : vbp_rd_r;
  assign y_rd  = cmd.phase ? tbp_rd_r : cell_rd_r;
  assign q_sel = cmd.phase ? tgt_r : spd_r;

  assign st.q_lt_x  = q_sel < x_rd;
  assign st.q_le_x  = q_sel <= x_rd;
  assign st.den_pos = den_r > 17'sd0;
  assign st.div_done = div_done;

  assign dq   = {q_sel[15], q_sel} - {xlo_r[15], xlo_r};
  assign dy   = {yhi_r[15], yhi_r} - {ylo_r[15], ylo_r};
  assign dx   = {xhi_r[15], xhi_r} - {xlo_r[15], xlo_r};
  assign prod = dq * dy;

  always_ff @(posedge clk) begin
    if (cmd.load_q) begin
      spd_r <= in_data.speed;
      tgt_r <= in_data.target_accel;
    end
    if (cmd.prev_ld) prev_r <= x_rd;
    if (cmd.hit_interp) begin
      xlo_r <= prev_r;
      xhi_r <= x_rd;
    end else if (cmd.hit_clamp) begin
      xlo_r <= x_rd;
      xhi_r <= x_rd;
    end
    if (cmd.ylo_ld) ylo_r <= y_rd;
    if (cmd.yhi_ld) yhi_r <= y_rd;
    if (cmd.mul) begin
      num_r <= prod;
      den_r <= dx;
    end
  end

  assign num_abs = num_r[33] ? -num_r : num_r;

  tfaml_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (num_abs[tfaml_pkg::NUM_W-1:0]),
    .divisor  (den_r[tfaml_pkg::DEN_W-1:0]),
    .quotient (quot),
    .done     (div_done)
  );

  assign squot = num_r[33] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign sum   = 35'(ylo_r) + 35'(squot);

  always_comb begin
    if (!st.den_pos)                res = yhi_r;
    else if (sum > 35'sd32767)      res = 16'sh7fff;
    else if (sum < -35'sd32768)     res = 16'sh8000;
    else                            res = sum[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= cmd.out_fire;
    if (cmd.out_fire) begin
      out_r.throttle_out     <= cmd.out_brake ? 16'sd0 : res;
      out_r.in_throttle_area <= !cmd.out_brake;
      out_r.at_max_throttle  <= cmd.out_max;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* sv/tfaml_ctrl.sv */
// Controller: config registers, breakpoint scan and per-row sequencing.
module tfaml_ctrl #(
  parameter int MAXC = 8,
  parameter int MAXR = 8,
  parameter int IW   = 3
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  tfaml_pkg::func_t                    func,
  output logic                                busy,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tfaml_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tfaml_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  tfaml_pkg::stat_t                    st,
  output tfaml_pkg::cmd_t                     cmd,
  output logic [IW-1:0]                       x_addr,
  output logic [IW-1:0]                       y_idx,
  output logic [IW-1:0]                       y_row
);

  localparam int NW = IW + 1;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_RD0  = 14'b00000000000010,
    S_CK0  = 14'b00000000000100,
    S_RDL  = 14'b00000000001000,
    S_CKL  = 14'b00000000010000,
    S_RDI  = 14'b00000000100000,
    S_CKI  = 14'b00000001000000,
    S_YLO  = 14'b00000010000000,
    S_YHI  = 14'b00000100000000,
    S_YWT  = 14'b00001000000000,
    S_MUL  = 14'b00010000000000,
    S_CHK  = 14'b00100000000000,
    S_DIV  = 14'b01000000000000,
    S_FIN  = 14'b10000000000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [3:0]    vcols_r, vcols_nxt, trows_r, trows_nxt;
  logic          phase_r, phase_nxt, max_r, max_nxt, eq0_r, eq0_nxt;
  logic [IW-1:0] idx_r, idx_nxt, lo_r, lo_nxt, hi_r, hi_nxt, row_r, row_nxt;
  logic [NW-1:0] nc, nr, n, n_m1, nr_m1;
  logic          accept;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;

  always_comb begin
    vcols_nxt = vcols_r;
    trows_nxt = trows_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tfaml_pkg::CFG_VEL_COLS: vcols_nxt = cfg_data;
        tfaml_pkg::CFG_THR_ROWS: trows_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (vcols_r < 4'd2)            nc = NW'(2);
    else if (32'(vcols_r) > MAXC)  nc = NW'(MAXC);
    else                           nc = NW'(vcols_r);
    if (trows_r < 4'd2)            nr = NW'(2);
    else if (32'(trows_r) > MAXR)  nr = NW'(MAXR);
    else                           nr = NW'(trows_r);
  end

  assign n     = phase_r ? nr : nc;
  assign n_m1  = n - 1'b1;
  assign nr_m1 = nr - 1'b1;

  always_comb begin
    unique case (state_r)
      S_RD0:   x_addr = '0;
      S_RDL:   x_addr = n_m1[IW-1:0];
      default: x_addr = idx_r;
    endcase
  end
  assign y_idx = (state_r == S_YHI) ? hi_r : lo_r;
  assign y_row = row_r;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    max_nxt   = max_r;
    eq0_nxt   = eq0_r;
    idx_nxt   = idx_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    row_nxt   = row_r;
    cmd       = '0;
    cmd.phase = phase_r;
    cmd.out_max = max_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (func == tfaml_pkg::FUNC_QUERY) begin
            cmd.load_q = 1'b1;
            phase_nxt  = 1'b0;
            max_nxt    = 1'b0;
            state_nxt  = S_RD0;
          end else begin
            cmd.write_en = 1'b1;
          end
        end
      end
      S_RD0: state_nxt = S_CK0;
      S_CK0: begin
        if (phase_r && st.q_lt_x) begin
          cmd.out_fire  = 1'b1;
          cmd.out_brake = 1'b1;
          state_nxt     = S_IDLE;
        end else if (st.q_le_x && !phase_r) begin
          cmd.hit_clamp = 1'b1;
          lo_nxt    = '0;
          hi_nxt    = '0;
          row_nxt   = '0;
          state_nxt = S_YLO;
        end else begin
          // target equal to the first row value: max check against the last
          // row still comes first, then it clamps low
          cmd.prev_ld = 1'b1;
          eq0_nxt     = st.q_le_x;
          state_nxt   = S_RDL;
        end
      end
      S_RDL: state_nxt = S_CKL;
      S_CKL: begin
        if (!st.q_lt_x || eq0_r) begin
          // at or past the last breakpoint; above it in throttle stage means max
          if (phase_r && !st.q_le_x) max_nxt = 1'b1;
          cmd.hit_clamp = 1'b1;
          if (eq0_r && st.q_le_x) begin
            lo_nxt = '0;
            hi_nxt = '0;
          end else begin
            lo_nxt = n_m1[IW-1:0];
            hi_nxt = n_m1[IW-1:0];
          end
          row_nxt   = '0;
          state_nxt = S_YLO;
        end else begin
          idx_nxt   = IW'(1);
          state_nxt = S_RDI;
        end
      end
      S_RDI: state_nxt = S_CKI;
      S_CKI: begin
        if (st.q_le_x || ({1'b0, idx_r} == n_m1)) begin
          cmd.hit_interp = 1'b1;
          lo_nxt    = idx_r - 1'b1;
          hi_nxt    = idx_r;
          row_nxt   = '0;
          state_nxt = S_YLO;
        end else begin
          cmd.prev_ld = 1'b1;
          idx_nxt     = idx_r + 1'b1;
          state_nxt   = S_RDI;
        end
      end
      S_YLO: state_nxt = S_YHI;
      S_YHI: begin
        cmd.ylo_ld = 1'b1;
        state_nxt  = S_YWT;
      end
      S_YWT: begin
        cmd.yhi_ld = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (st.den_pos) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DIV: if (st.div_done) state_nxt = S_FIN;
      S_FIN: begin
        if (phase_r) begin
          cmd.out_fire = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.acc_wr = 1'b1;
          if ({1'b0, row_r} == nr_m1) begin
            phase_nxt = 1'b1;
            state_nxt = S_RD0;
          end else begin
            row_nxt   = row_r + 1'b1;
            state_nxt = S_YLO;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vcols_r <= 4'd8;
      trows_r <= 4'd8;
      phase_r <= 1'b0;
      max_r   <= 1'b0;
      eq0_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vcols_r <= vcols_nxt;
      trows_r <= trows_nxt;
      phase_r <= phase_nxt;
      max_r   <= max_nxt;
      eq0_r   <= eq0_nxt;
    end
    idx_r <= idx_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    row_r <= row_nxt;
  end

  a_idle_only_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> $past(cmd.out_fire))
    else $error("returned to idle without a result");

  a_query_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && func == tfaml_pkg::FUNC_QUERY) |=> busy)
    else $error("query accepted but block not busy");

  a_div_needs_pos_den: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> st.den_pos)
    else $error("divider started with non-positive divisor");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CKI) |-> ({1'b0, idx_r} <= n_m1 && idx_r != '0))
    else $error("breakpoint scan index out of range");

endmodule

/* sv/throttle_from_accel_map_lookup_top.sv */
// Top level of the throttle-from-acceleration map lookup.
//
// Usage:
//  - Input channel: an item transfers at a rising edge with start high and
//    busy low. func selects write velocity breakpoint, write throttle
//    breakpoint, write map cell, or query. Writes complete in that cycle and
//    produce no result; busy stays low.
//  - A query raises busy. Every used map row is interpolated at the speed
//    (clamped to the end columns), then the throttle is interpolated against
//    the target acceleration (0 below row 0). One result shows on out_data
//    for a single cycle with out_valid high; the receiver cannot stall it.
//  - Each interpolation over a positive breakpoint span runs a 33-step
//    restoring divider; the breakpoint scans read each table entry in a
//    read state, then compare it in a check state. busy drops in the
//    result cycle, so the next item can transfer then.
//  - Config channel: cfg_ready is always high; index 0 sets the velocity
//    column count, index 1 the throttle row count (clamped to 2..max).
//    Write config only while idle.
//  - Reset: counts return to 8; the tables are not cleared and must be
//    loaded before querying.
module throttle_from_accel_map_lookup_top #(
  parameter int MAX_VELOCITY_COLUMNS = 8,
  parameter int MAX_THROTTLE_ROWS    = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  tfaml_pkg::in_t                    in_data,
  output logic                              out_valid,
  output tfaml_pkg::out_t                   out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tfaml_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tfaml_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // index width covers the larger of the two table dimensions
  localparam int MAXI = (MAX_VELOCITY_COLUMNS > MAX_THROTTLE_ROWS) ?
                        MAX_VELOCITY_COLUMNS : MAX_THROTTLE_ROWS;
  localparam int IW   = $clog2(MAXI);

  tfaml_pkg::cmd_t  cmd;
  tfaml_pkg::stat_t st;
  logic [IW-1:0]    x_addr, y_idx, y_row;

  // sequencer: owns counts, scan indices and row loop
  tfaml_ctrl #(
    .MAXC (MAX_VELOCITY_COLUMNS),
    .MAXR (MAX_THROTTLE_ROWS),
    .IW   (IW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .func      (in_data.func),
    .busy      (busy),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .st        (st),
    .cmd       (cmd),
    .x_addr    (x_addr),
    .y_idx     (y_idx),
    .y_row     (y_row)
  );

  // tables, arithmetic and the result register
  tfaml_dpath #(
    .MAXC (MAX_VELOCITY_COLUMNS),
    .MAXR (MAX_THROTTLE_ROWS),
    .IW   (IW)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .x_addr    (x_addr),
    .y_idx     (y_idx),
    .y_row     (y_row),
    .st        (st),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
